>>> sv/rc_channel_normalizer_assert.svh
// ----------------------------------------------------------------------------
// RC channel normalizer assertion macros
// Shared concurrent assertion forms used by the normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_NORMALIZER_ASSERT_SVH
`define RC_CHANNEL_NORMALIZER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define RCN_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RCN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/rcn_pkg.sv
// ----------------------------------------------------------------------------
// RC channel normalizer package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package rcn_pkg;

    localparam int RCN_RAW_W         = 16;
    localparam int RCN_POS_W         = 16;
    localparam int RCN_ADDR_W        = 3;
    localparam int RCN_FRACTION_BITS = 15;

    localparam logic [RCN_RAW_W-1:0] RCN_MIN_RESET  = 16'd1000;
    localparam logic [RCN_RAW_W-1:0] RCN_MAX_RESET  = 16'd2000;
    localparam logic [RCN_RAW_W-1:0] RCN_TRIM_RESET = 16'd1500;
    localparam logic [RCN_RAW_W-1:0] RCN_DEAD_RESET = 16'd0;

    typedef enum logic [RCN_ADDR_W-1:0] {
        REG_MIN     = 3'd0,
        REG_MAX     = 3'd1,
        REG_TRIM    = 3'd2,
        REG_DEAD    = 3'd3,
        REG_REVERSE = 3'd4
    } rcn_reg_t;

    typedef enum logic [1:0] {
        SW_OFF = 2'd0,
        SW_MID = 2'd1,
        SW_ON  = 2'd2
    } rcn_switch_t;

    typedef struct packed {
        logic        neg;
        rcn_switch_t sw;
        logic        cal_ok;
    } rcn_side_t;

endpackage

`default_nettype wire

>>> sv/rcn_div_stage.sv
// ----------------------------------------------------------------------------
// RC channel normalizer divider stage
// One registered restoring-division step that produces one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rcn_div_stage
    import rcn_pkg::*;
#(
    parameter int FRACTION_BITS = RCN_FRACTION_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [RCN_RAW_W+FRACTION_BITS-1:0]  in_word,
    input  wire logic [RCN_RAW_W-1:0]                in_den,
    input  wire rcn_side_t                           in_side,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [RCN_RAW_W+FRACTION_BITS-1:0]       out_word,
    output logic [RCN_RAW_W-1:0]                     out_den,
    output rcn_side_t                                out_side
);

    localparam int DW = RCN_RAW_W + FRACTION_BITS;

    logic              valid_reg;
    logic [DW-1:0]     word_reg;
    logic [DW-1:0]     word_next;
    logic [RCN_RAW_W-1:0] den_reg;
    rcn_side_t         side_reg;

    logic [RCN_RAW_W:0]   trial;
    logic [RCN_RAW_W:0]   diff;
    logic                 ge;
    logic [RCN_RAW_W-1:0] rem_next;

    // The upper bits hold the partial remainder, the lower bits the dividend
    // bits still to come followed by the quotient bits already found.
    always_comb begin
        trial     = in_word[DW-1:FRACTION_BITS-1];
        diff      = trial - {1'b0, in_den};
        ge        = trial >= {1'b0, in_den};
        rem_next  = ge ? diff[RCN_RAW_W-1:0] : trial[RCN_RAW_W-1:0];
        word_next = {rem_next, in_word[FRACTION_BITS-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

>>> sv/rc_channel_normalizer.sv
// ----------------------------------------------------------------------------
// RC channel normalizer
// Turns a raw pulse value into a Q1.15 stick position with dead zone,
// a three-way switch position and a calibration flag.
// ----------------------------------------------------------------------------
// The block accepts one raw value per clock cycle while the output side does
// not stall, and returns one result per input, in order. An input register is
// followed by three stages that compute the band limits, select and clamp the
// numerator and denominator, and form the dividend; a chain of FRACTION_BITS
// restoring-division stages then yields one quotient bit each, and a last
// stage applies the sign into the output register. Empty stages fill while
// the output waits, so input transfers continue until the pipeline is full.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce this.
`default_nettype none

`include "rc_channel_normalizer_assert.svh"

module rc_channel_normalizer
    import rcn_pkg::*;
#(
    parameter int FRACTION_BITS = RCN_FRACTION_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] raw_value
    input  wire logic [15:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [15:0] position, [17:16] switch_state, [18] calibration_ok,
    // [23:19] zero
    output logic [23:0]                 m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [RCN_ADDR_W-1:0]  cfg_addr,
    input  wire logic [15:0]            cfg_wdata
);

    localparam int RW = RCN_RAW_W;
    localparam int DW = RCN_RAW_W + FRACTION_BITS;

    // Configuration registers.
    logic [RW-1:0] min_reg;
    logic [RW-1:0] max_reg;
    logic [RW-1:0] trim_reg;
    logic [RW-1:0] dead_reg;
    logic          reverse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= RCN_MIN_RESET;
            max_reg     <= RCN_MAX_RESET;
            trim_reg    <= RCN_TRIM_RESET;
            dead_reg    <= RCN_DEAD_RESET;
            reverse_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN:     min_reg     <= cfg_wdata;
                REG_MAX:     max_reg     <= cfg_wdata;
                REG_TRIM:    trim_reg    <= cfg_wdata;
                REG_DEAD:    dead_reg    <= cfg_wdata;
                REG_REVERSE: reverse_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake signals.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    logic div_in_ready;
    logic out_ready;

    // Stage 1: input register.
    logic [RW-1:0] raw1_reg;

    assign r1       = !v1_reg || r2;
    assign s_tready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (r1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && s_tvalid) begin
            raw1_reg <= s_tdata;
        end
    end

    // Stage 2: band limits, side selection and candidate differences.
    logic signed [RW+1:0] lo_c;
    logic signed [RW+1:0] raw_s;
    logic signed [RW+1:0] min_s;
    logic [RW:0]          hi_c;
    logic                 lower_c;
    logic                 upper_c;
    logic                 cal_c;
    logic [RW-1:0]        lnum_c, lden_c, unum_c, uden_c;

    logic          lower2_reg, upper2_reg, cal2_reg;
    logic [RW-1:0] lnum2_reg, lden2_reg, unum2_reg, uden2_reg;

    always_comb begin
        raw_s   = $signed({2'b00, raw1_reg});
        min_s   = $signed({2'b00, min_reg});
        lo_c    = $signed({2'b00, trim_reg}) - $signed({2'b00, dead_reg});
        hi_c    = {1'b0, trim_reg} + {1'b0, dead_reg};
        cal_c   = (min_reg < trim_reg) && (trim_reg < max_reg);
        lower_c = (raw_s < lo_c) && (lo_c > min_s);
        upper_c = ({1'b0, raw1_reg} > hi_c) && ({1'b0, max_reg} > hi_c);
        lnum_c  = RW'(lo_c - raw_s);
        lden_c  = RW'(lo_c - min_s);
        unum_c  = RW'({1'b0, raw1_reg} - hi_c);
        uden_c  = RW'({1'b0, max_reg} - hi_c);
    end

    assign r2 = !v2_reg || r3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (r2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r2 && v1_reg) begin
            lower2_reg <= cal_c && lower_c;
            upper2_reg <= cal_c && !lower_c && upper_c;
            cal2_reg   <= cal_c;
            lnum2_reg  <= lnum_c;
            lden2_reg  <= lden_c;
            unum2_reg  <= unum_c;
            uden2_reg  <= uden_c;
        end
    end

    // Stage 3: numerator and denominator, clamp, switch decision.
    logic [RW-1:0] num_c, den_c, numc_c;
    logic          half_c;
    rcn_side_t     side_c;

    logic [RW-1:0] num3_reg, den3_reg;
    rcn_side_t     side3_reg;

    always_comb begin
        if (lower2_reg) begin
            num_c = lnum2_reg;
            den_c = lden2_reg;
        end else if (upper2_reg) begin
            num_c = unum2_reg;
            den_c = uden2_reg;
        end else begin
            num_c = '0;
            den_c = RW'(1);
        end
        numc_c        = (num_c > den_c) ? den_c : num_c;
        half_c        = {num_c, 1'b0} > {1'b0, den_c};
        side_c.neg    = lower2_reg ^ reverse_reg;
        side_c.cal_ok = cal2_reg;
        if (half_c) begin
            side_c.sw = side_c.neg ? SW_OFF : SW_ON;
        end else begin
            side_c.sw = SW_MID;
        end
    end

    assign r3 = !v3_reg || r4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (r3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r3 && v2_reg) begin
            num3_reg  <= numc_c;
            den3_reg  <= den_c;
            side3_reg <= side_c;
        end
    end

    // Stage 4: dividend num * (2^FRACTION_BITS - 1).
    logic [DW-1:0] dvd4_reg;
    logic [RW-1:0] num4_reg;
    logic [RW-1:0] den4_reg;
    rcn_side_t     side4_reg;

    assign r4 = !v4_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (r4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r4 && v3_reg) begin
            dvd4_reg  <= {num3_reg, {FRACTION_BITS{1'b0}}} - DW'(num3_reg);
            num4_reg  <= num3_reg;
            den4_reg  <= den3_reg;
            side4_reg <= side3_reg;
        end
    end

    // Divider chain: one quotient bit per stage.
    logic          dv_valid [0:FRACTION_BITS];
    logic          dv_ready [0:FRACTION_BITS];
    logic [DW-1:0] dv_word  [0:FRACTION_BITS];
    logic [RW-1:0] dv_den   [0:FRACTION_BITS];
    rcn_side_t     dv_side  [0:FRACTION_BITS];

    assign dv_valid[0] = v4_reg;
    assign dv_word[0]  = dvd4_reg;
    assign dv_den[0]   = den4_reg;
    assign dv_side[0]  = side4_reg;
    assign div_in_ready = dv_ready[0];
    assign dv_ready[FRACTION_BITS] = out_ready;

    for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div
        rcn_div_stage #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_word   (dv_word[i]),
            .in_den    (dv_den[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_word  (dv_word[i+1]),
            .out_den   (dv_den[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    // Output stage: sign and result register.
    logic [RCN_POS_W-1:0] mag_c;
    logic [RCN_POS_W-1:0] pos_c;
    logic                 out_valid_reg;
    logic [RCN_POS_W-1:0] out_pos_reg;
    rcn_switch_t          out_sw_reg;
    logic                 out_cal_reg;
    rcn_side_t            last_side;
    logic [RW-1:0]        last_rem;

    assign last_side = dv_side[FRACTION_BITS];
    assign last_rem  = dv_word[FRACTION_BITS][DW-1:FRACTION_BITS];

    always_comb begin
        mag_c = RCN_POS_W'(dv_word[FRACTION_BITS][FRACTION_BITS-1:0]);
        pos_c = last_side.neg ? RCN_POS_W'(-mag_c) : mag_c;
    end

    assign out_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= dv_valid[FRACTION_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && dv_valid[FRACTION_BITS]) begin
            out_pos_reg <= pos_c;
            out_sw_reg  <= last_side.sw;
            out_cal_reg <= last_side.cal_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_cal_reg, out_sw_reg, out_pos_reg};

    `RCN_ASSERT_IMPLY(a_bad_cal_neutral, aclk, aresetn, out_valid_reg && !out_cal_reg, out_pos_reg == '0 && out_sw_reg == SW_MID, "bad calibration must give a neutral result")
    `RCN_ASSERT_IMPLY(a_num_clamped, aclk, aresetn, v4_reg, num4_reg <= den4_reg && den4_reg != '0, "numerator must be clamped to a nonzero denominator")
    `RCN_ASSERT_IMPLY(a_rem_below_den, aclk, aresetn, dv_valid[FRACTION_BITS], last_rem < dv_den[FRACTION_BITS], "final remainder must be below the denominator")

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// RC channel normalizer testbench
// Streams raw pulse values through rc_channel_normalizer under a series of
// calibrations and checks every result transfer against a local prediction
// of position, switch state, calibration flag and padding.
// ----------------------------------------------------------------------------
module testbench
    import rcn_pkg::*;
();

    localparam int     PIPE_LATENCY = RCN_FRACTION_BITS + 5;
    localparam int     STALL_LIMIT  = 5000;
    localparam longint POS_SCALE    = (longint'(1) << RCN_FRACTION_BITS) - 1;

    typedef struct packed {
        logic [4:0]  pad;
        logic        cal_ok;
        rcn_switch_t sw;
        logic [15:0] position;
    } norm_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [RCN_ADDR_W-1:0] cfg_addr  = '0;
    logic [15:0]           cfg_wdata = '0;

    logic [15:0] cal_min     = RCN_MIN_RESET;
    logic [15:0] cal_max     = RCN_MAX_RESET;
    logic [15:0] cal_trim    = RCN_TRIM_RESET;
    logic [15:0] cal_dead    = RCN_DEAD_RESET;
    logic        cal_reverse = 1'b0;

    logic [15:0]  raw_pending[$];
    norm_result_t result_queue[$];
    int           idle_pct   = 30;
    int           errors     = 0;
    int           stall_cnt  = 0;

    rc_channel_normalizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic norm_result_t normalize_raw(logic [15:0] raw);
        longint       r, mn, mx, tr, dz, lo, hi, num, den, mag, pos;
        logic         neg;
        norm_result_t res;
        r   = longint'(raw);
        mn  = longint'(cal_min);
        mx  = longint'(cal_max);
        tr  = longint'(cal_trim);
        dz  = longint'(cal_dead);
        lo  = tr - dz;
        hi  = tr + dz;
        num = 0;
        den = 1;
        neg = 1'b0;
        res = '0;
        res.sw = SW_MID;
        if (!(mn < tr && tr < mx)) begin
            return res;
        end
        if (r < lo && lo > mn) begin
            num = lo - r;
            den = lo - mn;
            neg = 1'b1;
        end else if (r > hi && mx > hi) begin
            num = r - hi;
            den = mx - hi;
        end
        if (num > den) begin
            num = den;
        end
        if (cal_reverse) begin
            neg = !neg;
        end
        mag = (num * POS_SCALE) / den;
        pos = neg ? -mag : mag;
        if (2 * num > den) begin
            res.sw = neg ? SW_OFF : SW_ON;
        end
        res.position = pos[15:0];
        res.cal_ok   = 1'b1;
        return res;
    endfunction

    // The driver holds each item until its transfer completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_queue.push_back(normalize_raw(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (raw_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= raw_pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        norm_result_t got, want;
        m_tready <= ($urandom_range(99) >= idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (result_queue.size() == 0) begin
                $error("result transfer with no expected result: %h", m_tdata);
                errors++;
            end else begin
                want = result_queue.pop_front();
                if (got.position !== want.position) begin
                    $error("position expected %0d actual %0d",
                           $signed(want.position), $signed(got.position));
                    errors++;
                end
                if (got.sw !== want.sw) begin
                    $error("switch_state expected %0d actual %0d", want.sw, got.sw);
                    errors++;
                end
                if (got.cal_ok !== want.cal_ok) begin
                    $error("calibration_ok expected %0d actual %0d",
                           want.cal_ok, got.cal_ok);
                    errors++;
                end
                if (got.pad !== want.pad) begin
                    $error("padding expected %0d actual %0d", want.pad, got.pad);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else if (raw_pending.size() > 0 || result_queue.size() > 0 || s_tvalid) begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("rc_channel_normalizer test failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (raw_pending.size() > 0 || s_tvalid || result_queue.size() > 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LATENCY + 5) @(posedge aclk);
    endtask

    // Writes all five registers, then one random index past the register list.
    task automatic apply_config(logic [15:0] mn, logic [15:0] mx, logic [15:0] tr,
                                logic [15:0] dz, logic rev);
        logic [RCN_ADDR_W-1:0] idx;
        logic [15:0]           val;
        for (int i = 0; i < 6; i++) begin
            case (i)
                0: begin idx = REG_MIN;  val = mn; end
                1: begin idx = REG_MAX;  val = mx; end
                2: begin idx = REG_TRIM; val = tr; end
                3: begin idx = REG_DEAD; val = dz; end
                4: begin
                    idx = REG_REVERSE;
                    val = (16'($urandom) & 16'hFFFE) | 16'(rev);
                end
                default: begin
                    idx = RCN_ADDR_W'($urandom_range(REG_REVERSE + 1, 7));
                    val = 16'($urandom);
                end
            endcase
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= val;
            case (rcn_reg_t'(idx))
                REG_MIN:     cal_min     = val;
                REG_MAX:     cal_max     = val;
                REG_TRIM:    cal_trim    = val;
                REG_DEAD:    cal_dead    = val;
                REG_REVERSE: cal_reverse = val[0];
                default: ;
            endcase
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int mn, mx, tr, dz, lo_r, hi_r;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset calibration: ends, center, both exact half points and neighbors.
        raw_pending = '{16'd0, 16'd65535, 16'd1000, 16'd2000, 16'd1500, 16'd1499,
                        16'd1501, 16'd1250, 16'd1249, 16'd1750, 16'd1751};
        wait_drained();

        apply_config(16'd0, 16'd65535, 16'd32768, 16'd0, 1'b1);
        raw_pending = '{16'd0, 16'd65535, 16'd32768, 16'd16384, 16'd49152};
        wait_drained();

        // Calibration that fails the ordering, including trim equal to an end.
        apply_config(16'd2000, 16'd1000, 16'd1500, 16'd10, 1'b0);
        raw_pending = '{16'd1500, 16'd0};
        wait_drained();
        apply_config(16'd1500, 16'd2000, 16'd1500, 16'd0, 1'b0);
        raw_pending = '{16'd65535};
        wait_drained();

        // Dead band reaching each end, then past both ends.
        apply_config(16'd1000, 16'd2000, 16'd1500, 16'd500, 1'b0);
        raw_pending = '{16'd0, 16'd65535};
        wait_drained();
        apply_config(16'd0, 16'd65535, 16'd1, 16'd65535, 1'b1);
        raw_pending = '{16'd0, 16'd65535, 16'd1};
        wait_drained();

        for (int ph = 0; ph < 14; ph++) begin
            idle_pct = (ph == 6) ? 0 : 30;
            if ($urandom_range(4) == 0) begin
                mn = $urandom_range(0, 65535);
                mx = $urandom_range(0, 65535);
                tr = $urandom_range(0, 65535);
                dz = $urandom_range(0, 65535);
            end else begin
                mn = $urandom_range(0, 65533);
                mx = $urandom_range(mn + 2, 65535);
                tr = $urandom_range(mn + 1, mx - 1);
                case ($urandom_range(3))
                    0: dz = 0;
                    1: dz = $urandom_range(0, 63);
                    2: dz = $urandom_range(0, (mx - mn) / 2);
                    default: dz = $urandom_range(0, 65535);
                endcase
            end
            apply_config(16'(mn), 16'(mx), 16'(tr), 16'(dz), 1'($urandom_range(1)));
            lo_r = (cal_min < 64) ? 0 : cal_min - 64;
            hi_r = (cal_max > 65471) ? 65535 : cal_max + 64;
            if (lo_r > hi_r) begin
                lo_r = 0;
                hi_r = 65535;
            end
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(9) < 6) begin
                    raw_pending.push_back(16'($urandom_range(lo_r, hi_r)));
                end else begin
                    raw_pending.push_back(16'($urandom));
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("rc_channel_normalizer test passed");
        end else begin
            $display("rc_channel_normalizer test failed");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/rcn_pkg.sv
sv/rcn_div_stage.sv
sv/rc_channel_normalizer.sv
test/testbench.sv
